FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/gcr_pkg.sv
// Package for the gradient color ramp: constants, types, codes.
// No dependencies.
`default_nettype none
package gcr_pkg;
    localparam int MaxStops = 16;
    localparam int IdxW     = $clog2(MaxStops);
    localparam int CntW     = $clog2(MaxStops + 1);
    localparam int PosW     = 13;
    localparam logic [PosW-1:0] PosOne = 13'd4096;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_REM  = 2'd1;
    localparam logic [1:0] FUNC_EVAL = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOTFD = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_LAST, S_SHIFT, S_FETCH_LO, S_FETCH_UP,
        S_FETCH_WAIT, S_DIV, S_DONE
    } t_state;

    // Divider request bundle: start, numerators and denominator.
    typedef struct packed {
        logic        start;
        logic [20:0] num_r;
        logic [20:0] num_g;
        logic [20:0] num_b;
        logic [12:0] den;
    } t_div_req;
endpackage
`default_nettype wire

FILE: rtl/core/gcr_div.sv
// Three-lane restoring divider, one quotient bit per cycle.
// Depends on gcr_pkg.
`default_nettype none
module gcr_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gcr_pkg::t_div_req i_req,
    output logic                 o_busy,
    output logic [7:0]           o_q_r,
    output logic [7:0]           o_q_g,
    output logic [7:0]           o_q_b
);
    import gcr_pkg::*;
    // Quotient fits 8 bits, so 8 steps starting at bit 7.
    logic [3:0]  r_cnt;
    logic [20:0] r_rem [3];
    logic [7:0]  r_q   [3];
    logic [12:0] r_den;
    logic [20:0] n_rem [3];
    logic [7:0]  n_q   [3];
    logic [20:0] w_sub;
    logic [2:0]  w_sh;

    // cnt counts 8..1 while working; the quotient bit is cnt-1
    assign w_sh = 3'(r_cnt - 4'd1);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sub = {8'd0, r_den} << w_sh;
            if (r_rem[k] >= w_sub) begin
                n_rem[k] = r_rem[k] - w_sub;
                n_q[k]   = r_q[k] | (8'd1 << w_sh);
            end else begin
                n_rem[k] = r_rem[k];
                n_q[k]   = r_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= 4'd8;
        end else if (r_cnt != 4'd0) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem[0] <= i_req.num_r;
            r_rem[1] <= i_req.num_g;
            r_rem[2] <= i_req.num_b;
            for (int k = 0; k < 3; k++) r_q[k] <= '0;
            r_den <= i_req.den;
        end else if (r_cnt != 4'd0) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_busy = (r_cnt != 4'd0);
    assign o_q_r = r_q[0];
    assign o_q_g = r_q[1];
    assign o_q_b = r_q[2];
endmodule
`default_nettype wire

FILE: rtl/core/gcr_mem.sv
// Stop table memory: 13-bit position plus 24-bit color per entry.
// Depends on gcr_pkg.
`default_nettype none
module gcr_mem (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [gcr_pkg::IdxW-1:0] i_waddr,
    input  wire logic [36:0]             i_wdata,
    input  wire logic [gcr_pkg::IdxW-1:0] i_raddr,
    output logic [36:0]                  o_rdata
);
    import gcr_pkg::*;
    logic [36:0] r_mem [MaxStops];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/gradient_color_ramp.sv
// Top level of the gradient color ramp: sequencer around the stop table.
// Depends on gcr_pkg, gcr_mem, gcr_div, assert_macros.svh.
//
//  channel | signals                                  | dir
//  in      | i_valid/o_ready, func position rgb_in    | in
//  out     | o_valid/i_ready, status rgb_out count    | out
//
// Add: write the new stop at the end. Remove: scan up to the match, then shift
// the later entries down through the memory's single write port. Evaluate: scan
// all held stops (at most 16), fetch the two bounding stops, then divide. The next
// item is taken after the result leaves the output register. Reset clears the
// count and control only.
`default_nettype none
`include "assert_macros.svh"
module gradient_color_ramp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [12:0] i_position,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic [4:0]       o_stop_count
);
    import gcr_pkg::*;

    t_state r_state, n_state;
    logic [CntW-1:0] r_held;
    logic [1:0]  r_func;
    logic [12:0] r_pos;
    logic [23:0] r_col;
    logic [CntW-1:0] r_idx;      // read address sent last cycle
    logic [CntW-1:0] r_ptr;      // next read address
    logic        r_has_lo, r_has_up;
    logic [IdxW-1:0] r_lo, r_up;
    logic [12:0] r_lo_pos, r_up_pos;
    logic [23:0] r_lo_col, r_up_col;
    logic        r_dstart;
    logic        r_ovalid;

    logic        w_acc;
    logic [12:0] w_psat;
    logic        we;
    logic [IdxW-1:0] waddr, raddr;
    logic [36:0] wdata, rdata;
    logic [12:0] rd_pos;
    logic [23:0] rd_col;
    t_div_req    div_req;
    logic        div_busy;
    logic [7:0]  q_r, q_g, q_b;

    assign w_acc  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign w_psat = (i_position > PosOne) ? PosOne : i_position;
    assign rd_pos = rdata[36:24];
    assign rd_col = rdata[23:0];

    gcr_mem u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // Lerp numerators; weights are under 4097, channels 8 bits.
    logic [12:0] w_dn, w_dl, w_dist;
    assign w_dn   = r_up_pos - r_pos;
    assign w_dl   = r_pos - r_lo_pos;
    assign w_dist = r_up_pos - r_lo_pos;

    function automatic logic [20:0] num_f(input logic [7:0] lo, input logic [7:0] hi,
                                          input logic [12:0] a, input logic [12:0] b,
                                          input logic [12:0] d);
        num_f = 21'(lo * a) + 21'(hi * b) + 21'(d >> 1);
    endfunction

    always_comb begin
        div_req.start = r_dstart;
        div_req.num_r = num_f(r_lo_col[23:16], r_up_col[23:16], w_dn, w_dl, w_dist);
        div_req.num_g = num_f(r_lo_col[15:8],  r_up_col[15:8],  w_dn, w_dl, w_dist);
        div_req.num_b = num_f(r_lo_col[7:0],   r_up_col[7:0],   w_dn, w_dl, w_dist);
        div_req.den   = w_dist;
    end

    gcr_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_busy(div_busy),
        .o_q_r(q_r), .o_q_g(q_g), .o_q_b(q_b)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) begin
                if (i_func == FUNC_REM || i_func == FUNC_EVAL) begin
                    n_state = (r_held == '0) ? S_DONE : S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_func == FUNC_REM && r_idx != r_held && rd_pos == r_pos &&
                    rd_col == r_col) begin
                    n_state = S_SHIFT;
                end else if (r_idx + 1'b1 == r_held) begin
                    n_state = S_SCAN_LAST;
                end
            end
            // every held entry has been scanned; a remove got here without a match
            S_SCAN_LAST:  n_state = (r_func == FUNC_EVAL) ? S_FETCH_LO : S_DONE;
            S_SHIFT:      if (r_ptr >= r_held) n_state = S_DONE;
            S_FETCH_LO:   n_state = S_FETCH_UP;
            S_FETCH_UP:   n_state = S_FETCH_WAIT;
            S_FETCH_WAIT: n_state = (r_has_lo && r_has_up) ? S_DIV : S_DONE;
            S_DIV:        if (!r_dstart && !div_busy) n_state = S_DONE;
            S_DONE:       n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        we    = 1'b0;
        waddr = r_held[IdxW-1:0];
        wdata = {r_pos, r_col};
        raddr = r_ptr[IdxW-1:0];
        unique case (r_state)
            S_IDLE: begin
                raddr = '0;
                waddr = r_held[IdxW-1:0];
                wdata = {w_psat, i_red_in, i_green_in, i_blue_in};
                we    = w_acc && i_func == FUNC_ADD && r_held < CntW'(MaxStops);
            end
            S_SHIFT: begin
                // rdata holds entry r_idx; move it down one place
                waddr = IdxW'(r_idx - 1'b1);
                wdata = rdata;
                we    = (r_idx < r_held) && (r_idx != r_ptr);
            end
            S_FETCH_LO: raddr = r_lo;
            S_FETCH_UP: raddr = r_up;
            default: ;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dstart <= (r_state == S_FETCH_WAIT) && r_has_lo && r_has_up;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            if (we && r_state == S_IDLE) r_held <= r_held + 1'b1;
            if (r_state == S_SHIFT && n_state == S_DONE) r_held <= r_held - 1'b1;
        end
    end

    logic w_lo_take, w_up_take;
    assign w_lo_take = (rd_pos < r_pos) && (!r_has_lo || r_lo_pos < rd_pos);
    assign w_up_take = (rd_pos >= r_pos) && (!r_has_up || r_up_pos > rd_pos);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (w_acc) begin
                r_func   <= i_func;
                r_pos    <= w_psat;
                r_col    <= {i_red_in, i_green_in, i_blue_in};
                r_idx    <= '0;
                r_ptr    <= CntW'(1);
                r_has_lo <= 1'b0;
                r_has_up <= 1'b0;
                o_status <= ST_OK;
                o_red_out <= '0; o_green_out <= '0; o_blue_out <= '0;
                if (i_func == FUNC_ADD && r_held >= CntW'(MaxStops)) o_status <= ST_FULL;
                if ((i_func == FUNC_REM) && r_held == '0) o_status <= ST_NOTFD;
                if ((i_func == FUNC_EVAL) && r_held == '0) o_status <= ST_EMPTY;
            end
            S_SCAN: begin
                if (w_lo_take) begin
                    r_has_lo <= 1'b1; r_lo <= r_idx[IdxW-1:0]; r_lo_pos <= rd_pos;
                end
                if (w_up_take) begin
                    r_has_up <= 1'b1; r_up <= r_idx[IdxW-1:0]; r_up_pos <= rd_pos;
                end
                if (n_state == S_SHIFT) begin
                    // the entry after the match is read now; next read is the one after it
                    r_ptr <= r_idx + 2'd2;
                    r_idx <= r_idx + 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            S_SCAN_LAST: if (r_func == FUNC_REM) o_status <= ST_NOTFD;
            S_SHIFT: begin
                r_idx <= r_ptr;
                r_ptr <= r_ptr + 1'b1;
            end
            S_FETCH_WAIT: begin
                if (!r_has_lo) begin
                    {o_red_out, o_green_out, o_blue_out} <= rdata[23:0];
                end else if (!r_has_up) begin
                    {o_red_out, o_green_out, o_blue_out} <= r_lo_col;
                end
                r_up_col <= rdata[23:0];
            end
            S_FETCH_UP: r_lo_col <= rdata[23:0];
            S_DIV: if (!r_dstart && !div_busy) begin
                o_red_out <= q_r; o_green_out <= q_g; o_blue_out <= q_b;
            end
            default: ;
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_stop_count = 5'(r_held);

    `ASSERT_IMPLY(a_held_max, i_clk, i_rst_n, 1'b1, r_held <= CntW'(MaxStops))
    `ASSERT_IMPLY(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, o_valid)
endmodule
`default_nettype wire
